>>> rtl/mandelbrot_smooth_escape_pixel_defines.svh
// assertion macros for the smooth escape pixel block
`ifndef MANDELBROT_SMOOTH_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_SMOOTH_ESCAPE_PIXEL_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MSE_ASSERT_HOLD(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checks the cycle after reset
`define MSE_ASSERT_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

>>> rtl/mse_pkg.sv
// shared types, constants and saturating arithmetic for the smooth escape pixel block
`default_nettype none
package mse_pkg;

   localparam int WORD_W            = 64;
   localparam int PIX_W             = 12;
   localparam int SIZE_W            = 13;
   localparam int CENTER_W          = 53;
   localparam int SPAN_W            = 51;
   localparam int ITER_W            = 16;
   localparam int COLOR_W           = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 53;
   localparam int LOG_FB            = 24;
   localparam int MANT_FB           = 30;
   localparam int QUOT_EXT_W        = PIX_W + WORD_W;
   localparam int COLORS_DEF        = 256;
   localparam int FRACTION_BITS_DEF = 48;
   localparam int QUEUE_DEPTH_DEF   = 2;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [CENTER_W-1:0] CENTER_RESET = '0;
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = SPAN_W'(51'd1125899906842624);
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET = SIZE_W'(480);
   localparam logic [ITER_W-1:0]   ITER_RESET   = ITER_W'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X       = 3'd0,
      CSR_CENTER_Y       = 3'd1,
      CSR_SPAN_X         = 3'd2,
      CSR_SPAN_Y         = 3'd3,
      CSR_IMAGE_WIDTH    = 3'd4,
      CSR_IMAGE_HEIGHT   = 3'd5,
      CSR_MAX_ITERATIONS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] cx;
      logic signed [WORD_W-1:0] cy;
   } point_type;

   function automatic logic signed [WORD_W-1:0] sat_add(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b
   );
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sub(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b
   );
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/mse_mul.sv
// multi-cycle signed fixed point multiplier with saturation, one 32x32 partial product a cycle
`default_nettype none
module mse_mul import mse_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORD_W-1:0] op_a,
   input  logic signed [WORD_W-1:0] op_b,
   output logic                     done,
   output logic signed [WORD_W-1:0] result
);

   localparam int HALF_W = WORD_W / 2;
   localparam logic [2:0] LAST_PP   = 3'd3;
   localparam logic [2:0] CLAMP_STEP = 3'd5;
   localparam logic [2:0] LAST_STEP = 3'd6;

   logic                      busy_ff;
   logic                      done_ff;
   logic [2:0]                cnt_ff;
   logic [WORD_W-1:0]         ua_ff;
   logic [WORD_W-1:0]         ub_ff;
   logic                      neg_ff;
   logic [WORD_W-1:0]         pp_ff;
   logic [1:0]                pp_sh_ff;
   logic [2*WORD_W-1:0]       acc_ff;
   logic [WORD_W-1:0]         mag_ff;
   logic signed [WORD_W-1:0]  res_ff;

   logic [HALF_W-1:0]   a_half;
   logic [HALF_W-1:0]   b_half;
   logic [WORD_W-1:0]   pp_in;
   logic [1:0]          pp_sh_in;
   logic [2*WORD_W-1:0] pp_ext;
   logic [2*WORD_W-1:0] acc_in;
   logic [2*WORD_W-1:0] quot;
   logic [WORD_W-1:0]   lim;
   logic [WORD_W-1:0]   mag_in;
   logic                take;

   assign take   = start && !busy_ff;
   assign a_half = cnt_ff[1] ? ua_ff[WORD_W-1:HALF_W] : ua_ff[HALF_W-1:0];
   assign b_half = cnt_ff[0] ? ub_ff[WORD_W-1:HALF_W] : ub_ff[HALF_W-1:0];
   assign pp_in  = {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};
   assign pp_sh_in = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0]};

   always_comb begin
      unique case (pp_sh_ff)
         2'd0:    pp_ext = {{WORD_W{1'b0}}, pp_ff};
         2'd1:    pp_ext = {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
         2'd2:    pp_ext = {pp_ff, {WORD_W{1'b0}}};
         default: pp_ext = '0;
      endcase
   end

   assign acc_in = acc_ff + pp_ext;
   assign quot   = acc_ff >> FRACTION_BITS;
   assign lim    = neg_ff ? WORD_MIN : WORD_MAX;
   assign mag_in = ((|quot[2*WORD_W-1:WORD_W]) || (quot[WORD_W-1:0] > lim))
                   ? lim : quot[WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST_STEP);
         if (take) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ua_ff  <= op_a[WORD_W-1] ? (WORD_W'(0) - op_a) : op_a;
         ub_ff  <= op_b[WORD_W-1] ? (WORD_W'(0) - op_b) : op_b;
         neg_ff <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff <= LAST_PP) begin
            pp_ff    <= pp_in;
            pp_sh_ff <= pp_sh_in;
         end
         if (cnt_ff != 3'd0 && cnt_ff <= LAST_PP + 3'd1) begin
            acc_ff <= acc_in;
         end
         if (cnt_ff == CLAMP_STEP) begin
            mag_ff <= mag_in;
         end
         if (cnt_ff == LAST_STEP) begin
            res_ff <= neg_ff ? (WORD_W'(0) - mag_ff) : mag_ff;
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

>>> rtl/mse_front.sv
// front end: takes a pixel request, divides by the image size and maps it into the view
`default_nettype none
module mse_front import mse_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIX_W-1:0]           req_pixel_x,
   input  logic [PIX_W-1:0]           req_pixel_y,
   input  logic signed [CENTER_W-1:0] center_x,
   input  logic signed [CENTER_W-1:0] center_y,
   input  logic [SPAN_W-1:0]          span_x,
   input  logic [SPAN_W-1:0]          span_y,
   input  logic [SIZE_W-1:0]          image_width,
   input  logic [SIZE_W-1:0]          image_height,
   output logic                       pt_valid,
   input  logic                       pt_ready,
   output point_type                  pt_data
);

   localparam int DIV_STEPS = PIX_W + FRACTION_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam logic signed [WORD_W-1:0] HALF = WORD_W'(1) << (FRACTION_BITS - 1);

   typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_WAIT, F_PUSH} state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [PIX_W-1:0]      dvx_ff, dvy_ff;
   logic [SIZE_W-1:0]     sx_ff, sy_ff;
   logic [SIZE_W-1:0]     rx_ff, ry_ff;
   logic [DIV_STEPS-1:0]  qx_ff, qy_ff;
   point_type             pt_ff;

   logic [SIZE_W:0]          remx_t, remy_t;
   logic                     gex, gey;
   logic [SIZE_W-1:0]        rx_in, ry_in;
   logic [QUOT_EXT_W-1:0]    qxe, qye;
   logic signed [WORD_W-1:0] ratx, raty;
   logic signed [WORD_W-1:0] dx, dy;
   logic signed [WORD_W-1:0] mx_res, my_res;
   logic                     mx_done, my_done;
   logic                     mul_start;
   point_type                pt_in;

   assign remx_t = {rx_ff, dvx_ff[PIX_W-1]};
   assign remy_t = {ry_ff, dvy_ff[PIX_W-1]};
   assign gex    = remx_t >= {1'b0, sx_ff};
   assign gey    = remy_t >= {1'b0, sy_ff};
   assign rx_in  = gex ? SIZE_W'(remx_t - {1'b0, sx_ff}) : remx_t[SIZE_W-1:0];
   assign ry_in  = gey ? SIZE_W'(remy_t - {1'b0, sy_ff}) : remy_t[SIZE_W-1:0];

   assign qxe  = QUOT_EXT_W'(qx_ff);
   assign qye  = QUOT_EXT_W'(qy_ff);
   assign ratx = (|qxe[QUOT_EXT_W-1:WORD_W-1]) ? WORD_MAX : qxe[WORD_W-1:0];
   assign raty = (|qye[QUOT_EXT_W-1:WORD_W-1]) ? WORD_MAX : qye[WORD_W-1:0];
   assign dx   = ratx - HALF;
   assign dy   = raty - HALF;

   assign mul_start = state_ff == F_MUL;

   mse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_x (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (WORD_W'(span_x)),
      .op_b   (dx),
      .done   (mx_done),
      .result (mx_res)
   );

   mse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_y (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (WORD_W'(span_y)),
      .op_b   (dy),
      .done   (my_done),
      .result (my_res)
   );

   assign pt_in.cx = sat_add(mx_res, {{(WORD_W-CENTER_W){center_x[CENTER_W-1]}}, center_x});
   assign pt_in.cy = sat_add(my_res, {{(WORD_W-CENTER_W){center_y[CENTER_W-1]}}, center_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  state_ff <= F_DIV;
                  cnt_ff   <= '0;
               end
            end
            F_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= F_MUL;
               end
            end
            F_MUL: state_ff <= F_WAIT;
            F_WAIT: begin
               if (mx_done && my_done) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (pt_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         dvx_ff <= req_pixel_x;
         dvy_ff <= req_pixel_y;
         sx_ff  <= (image_width == '0) ? SIZE_W'(1) : image_width;
         sy_ff  <= (image_height == '0) ? SIZE_W'(1) : image_height;
         rx_ff  <= '0;
         ry_ff  <= '0;
         qx_ff  <= '0;
         qy_ff  <= '0;
      end else if (state_ff == F_DIV) begin
         dvx_ff <= {dvx_ff[PIX_W-2:0], 1'b0};
         dvy_ff <= {dvy_ff[PIX_W-2:0], 1'b0};
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         qx_ff  <= {qx_ff[DIV_STEPS-2:0], gex};
         qy_ff  <= {qy_ff[DIV_STEPS-2:0], gey};
      end
      if (state_ff == F_WAIT && mx_done && my_done) begin
         pt_ff <= pt_in;
      end
   end

   assign req_ready = state_ff == F_IDLE;
   assign pt_valid  = state_ff == F_PUSH;
   assign pt_data   = pt_ff;

endmodule
`default_nettype wire

>>> rtl/mse_queue.sv
// small request queue between the front and back ends
`default_nettype none
module mse_queue import mse_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  point_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output point_type out_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   point_type         slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              push, pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mse_back.sv
// back end: escape iteration, two-pass log2 and color, with the result register
`default_nettype none
module mse_back import mse_pkg::*; #(
   parameter int COLORS        = COLORS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pt_valid,
   output logic               pt_ready,
   input  point_type          pt_data,
   input  logic [ITER_W-1:0]  max_iterations,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COLOR_W-1:0] rsp_color_index,
   output logic               rsp_inside_res
);

   localparam int MANT_W = MANT_FB + 1;
   localparam int SQ_W   = 2 * MANT_W;
   localparam int LRES_W = 6 + LOG_FB;
   localparam int CLR_W  = $clog2(COLORS + 1);
   localparam int PROD_W = LOG_FB + CLR_W;
   localparam logic signed [WORD_W-1:0] FOUR = WORD_W'(4) << FRACTION_BITS;
   localparam logic [5:0] FB_MAIN = 6'(FRACTION_BITS);
   localparam logic [5:0] FB_LOG  = 6'(LOG_FB);
   localparam logic [4:0] LAST_SQ = 5'(LOG_FB - 1);

   typedef enum logic [3:0] {
      B_IDLE, B_STEP, B_WAIT, B_LNORM, B_LSQ, B_LDEC, B_COLOR, B_FIN
   } state_type;

   state_type                state_ff;
   logic signed [WORD_W-1:0] cx_ff, cy_ff;
   logic signed [WORD_W-1:0] sum_ff, diff_ff, p2_ff;
   logic [ITER_W:0]          hops_ff;
   logic [WORD_W-1:0]        lv_ff;
   logic [5:0]               lmsb_ff;
   logic                     lpass_ff;
   logic [MANT_W-1:0]        lmant_ff;
   logic [SQ_W-1:0]          lsq_ff;
   logic [LOG_FB-1:0]        lfr_ff;
   logic [4:0]               lcnt_ff;
   logic [LRES_W-1:0]        ll_ff;
   logic [COLOR_W-1:0]       res_color_ff;
   logic                     res_inside_ff;
   logic                     rsp_valid_ff;
   logic [COLOR_W-1:0]       rsp_color_ff;
   logic                     rsp_inside_ff;

   logic                     go, escaped, mul_start, mul_done;
   logic signed [WORD_W-1:0] x_in, y_in;
   logic signed [WORD_W-1:0] pxy, pxx, pyy;
   logic                     dxy, dxx, dyy;
   logic [5:0]               fb;
   logic [MANT_FB+1:0]       sq_top;
   logic                     sq_big;
   logic [LOG_FB-1:0]        lfr_in;
   logic [MANT_W-1:0]        lmant_in;
   logic                     ldone;
   logic [LRES_W-1:0]        lres;
   logic [5:0]               lexp;
   logic [LOG_FB-1:0]        frac;
   logic [PROD_W-1:0]        cprod;
   logic                     out_free;

   assign go      = (sum_ff <= FOUR) && (hops_ff <= {1'b0, max_iterations});
   assign escaped = hops_ff < {1'b0, max_iterations};
   assign x_in    = sat_add(diff_ff, cx_ff);
   assign y_in    = sat_add(p2_ff, cy_ff);
   assign mul_start = state_ff == B_STEP && go;
   assign mul_done  = dxy && dxx && dyy;

   mse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_xy (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(x_in), .op_b(y_in), .done(dxy), .result(pxy)
   );
   mse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_xx (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(x_in), .op_b(x_in), .done(dxx), .result(pxx)
   );
   mse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_yy (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(y_in), .op_b(y_in), .done(dyy), .result(pyy)
   );

   assign fb       = lpass_ff ? FB_LOG : FB_MAIN;
   assign sq_top   = lsq_ff[SQ_W-1:MANT_FB];
   assign sq_big   = sq_top[MANT_FB+1];
   assign lfr_in   = {lfr_ff[LOG_FB-2:0], sq_big};
   assign lmant_in = sq_big ? sq_top[MANT_FB+1:1] : sq_top[MANT_FB:0];
   assign lexp     = lmsb_ff - fb;

   always_comb begin
      ldone = 1'b0;
      lres  = '0;
      priority if (state_ff == B_LNORM) begin
         if (lv_ff == '0 || (lv_ff[WORD_W-1] && lmsb_ff < fb)) begin
            ldone = 1'b1;
         end
      end else if (state_ff == B_LDEC && lcnt_ff == LAST_SQ) begin
         ldone = 1'b1;
         lres  = {lexp, lfr_in};
      end else begin
         ldone = 1'b0;
      end
   end

   assign frac     = (ll_ff[LRES_W-1:LOG_FB] != '0) ? ll_ff[LOG_FB-1:0] : '0;
   assign cprod    = PROD_W'(frac) * PROD_W'(COLORS);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (pt_valid) begin
                  state_ff <= B_STEP;
               end
            end
            B_STEP: begin
               priority if (go) begin
                  state_ff <= B_WAIT;
               end else if (escaped) begin
                  state_ff <= B_LNORM;
               end else begin
                  state_ff <= B_FIN;
               end
            end
            B_WAIT: begin
               if (mul_done) begin
                  state_ff <= B_STEP;
               end
            end
            B_LNORM: begin
               priority if (ldone) begin
                  state_ff <= lpass_ff ? B_COLOR : B_LNORM;
               end else if (lv_ff[WORD_W-1]) begin
                  state_ff <= B_LSQ;
               end else begin
                  state_ff <= B_LNORM;
               end
            end
            B_LSQ: state_ff <= B_LDEC;
            B_LDEC: begin
               priority if (ldone) begin
                  state_ff <= lpass_ff ? B_COLOR : B_LNORM;
               end else begin
                  state_ff <= B_LSQ;
               end
            end
            B_COLOR: state_ff <= B_FIN;
            B_FIN: begin
               if (out_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            cx_ff   <= pt_data.cx;
            cy_ff   <= pt_data.cy;
            sum_ff  <= '0;
            diff_ff <= '0;
            p2_ff   <= '0;
            hops_ff <= '0;
         end
         B_STEP: begin
            if (go) begin
               hops_ff <= hops_ff + 1'b1;
            end else begin
               lv_ff         <= sum_ff;
               lmsb_ff       <= 6'd63;
               lpass_ff      <= 1'b0;
               res_color_ff  <= '0;
               res_inside_ff <= !escaped;
            end
         end
         B_WAIT: begin
            if (mul_done) begin
               sum_ff  <= sat_add(pxx, pyy);
               diff_ff <= sat_sub(pxx, pyy);
               p2_ff   <= sat_add(pxy, pxy);
            end
         end
         B_LNORM, B_LDEC: begin
            if (ldone) begin
               lv_ff    <= WORD_W'(lres);
               lmsb_ff  <= 6'd63;
               lpass_ff <= 1'b1;
               ll_ff    <= lres;
            end else if (state_ff == B_LDEC) begin
               lfr_ff   <= lfr_in;
               lmant_ff <= lmant_in;
               lcnt_ff  <= lcnt_ff + 1'b1;
            end else if (lv_ff[WORD_W-1]) begin
               lmant_ff <= lv_ff[WORD_W-1:WORD_W-MANT_W];
               lfr_ff   <= '0;
               lcnt_ff  <= '0;
            end else begin
               lv_ff   <= {lv_ff[WORD_W-2:0], 1'b0};
               lmsb_ff <= lmsb_ff - 6'd1;
            end
         end
         B_LSQ: lsq_ff <= SQ_W'(lmant_ff) * SQ_W'(lmant_ff);
         B_COLOR: res_color_ff <= COLOR_W'(cprod >> LOG_FB);
         B_FIN: begin
            if (out_free) begin
               rsp_color_ff  <= res_color_ff;
               rsp_inside_ff <= res_inside_ff;
            end
         end
         default: ;
      endcase
   end

   assign pt_ready        = state_ff == B_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_color_ff;
   assign rsp_inside_res  = rsp_inside_ff;

endmodule
`default_nettype wire

>>> rtl/mandelbrot_smooth_escape_pixel.sv
// top level of the smooth escape pixel block: registers, front end, queue, back end
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_pixel_x, req_pixel_y
//  rsp     | out       | rsp_valid/ready    | rsp_color_index, rsp_inside_res
//  csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// front end: a bit-serial divide, then the multi-cycle multiply, for each request
// back end: each iteration waits on the multi-cycle multiplier, then normalize and
// square steps follow for each of two log2 passes
// front and back overlap through the queue; the result register frees the back end
// synchronous reset clears control state and loads the register defaults
`default_nettype none
module mandelbrot_smooth_escape_pixel import mse_pkg::*; #(
   parameter int COLORS        = COLORS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel_x,
   input  logic [PIX_W-1:0]       req_pixel_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COLOR_W-1:0]     rsp_color_index,
   output logic                   rsp_inside_res,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic signed [CENTER_W-1:0] center_x_ff, center_y_ff;
   logic [SPAN_W-1:0]          span_x_ff, span_y_ff;
   logic [SIZE_W-1:0]          image_width_ff, image_height_ff;
   logic [ITER_W-1:0]          max_iterations_ff;

   logic      fq_valid, fq_ready, qb_valid, qb_ready;
   point_type fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff       <= CENTER_RESET;
         center_y_ff       <= CENTER_RESET;
         span_x_ff         <= SPAN_RESET;
         span_y_ff         <= SPAN_RESET;
         image_width_ff    <= WIDTH_RESET;
         image_height_ff   <= HEIGHT_RESET;
         max_iterations_ff <= ITER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X:       center_x_ff       <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Y:       center_y_ff       <= csr_data[CENTER_W-1:0];
            CSR_SPAN_X:         span_x_ff         <= csr_data[SPAN_W-1:0];
            CSR_SPAN_Y:         span_y_ff         <= csr_data[SPAN_W-1:0];
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data[SIZE_W-1:0];
            CSR_MAX_ITERATIONS: max_iterations_ff <= csr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   mse_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .span_x       (span_x_ff),
      .span_y       (span_y_ff),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .pt_valid     (fq_valid),
      .pt_ready     (fq_ready),
      .pt_data      (fq_data)
   );

   mse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   mse_back #(.COLORS(COLORS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pt_valid        (qb_valid),
      .pt_ready        (qb_ready),
      .pt_data         (qb_data),
      .max_iterations  (max_iterations_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .rsp_inside_res  (rsp_inside_res)
   );

endmodule
`default_nettype wire

>>> rtl/mse_checker.sv
// port-level checker for the smooth escape pixel block, bound to the top level
`default_nettype none
`include "mandelbrot_smooth_escape_pixel_defines.svh"
module mse_checker import mse_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [PIX_W-1:0]       req_pixel_x,
   input logic [PIX_W-1:0]       req_pixel_y,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COLOR_W-1:0]     rsp_color_index,
   input logic                   rsp_inside_res,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   logic [3:0] open_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (req_take && !rsp_take) begin
         open_ff <= open_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         open_ff <= open_ff - 4'd1;
      end
   end

   `MSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_color_index) && $stable(rsp_inside_res), "stalled result changed")
   `MSE_ASSERT_HOLD(a_inside_zero, rsp_valid && rsp_inside_res, rsp_color_index == '0, "inside point with nonzero color")
   `MSE_ASSERT_RESET(a_reset_idle, !rsp_valid, "result valid right after reset")
   `MSE_ASSERT_HOLD(a_no_orphan, rsp_valid, open_ff != '0, "result without an open request")

   logic unused_ok;
   assign unused_ok = ^{req_pixel_x, req_pixel_y, csr_valid, csr_ready, csr_index, csr_data};

endmodule

bind mandelbrot_smooth_escape_pixel mse_checker u_mse_checker (.*);
`default_nettype wire

>>> sim/mandelbrot_smooth_escape_pixel_tb.sv
// self-checking testbench for the smooth escape pixel block
`timescale 1ns / 100ps
`default_nettype none
module mandelbrot_smooth_escape_pixel_tb;
   import mse_pkg::*;

   typedef logic signed [63:0] word_type;
   typedef enum {STEP_PIXEL, STEP_CSR, STEP_DRAIN, STEP_MODE} step_kind_type;
   typedef struct {
      step_kind_type kind;
      csr_index_type idx;
      logic [CSR_DATA_W-1:0] data;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      int gap;
      int stall;
   } step_type;
   typedef struct {
      logic [COLOR_W-1:0] color;
      logic in_set;
   } shade_type;

   localparam word_type W_MAX = 64'sh7fffffffffffffff;
   localparam word_type W_MIN = 64'sh8000000000000000;
   localparam int FB = 48;
   localparam int N_COLORS = 256;
   localparam longint CYCLE_LIMIT = 20000000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic [PIX_W-1:0] req_pixel_x, req_pixel_y;
   logic [COLOR_W-1:0] rsp_color_index;
   logic rsp_inside_res;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   step_type pending_steps[$];
   shade_type expected_shades[$];
   word_type view_cx, view_cy;
   logic [63:0] view_sx, view_sy, view_w, view_h, iter_limit;
   int gap_pct, stall_pct, drain_cnt, errors;
   longint cycles;

   mandelbrot_smooth_escape_pixel i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic word_type s_add(word_type a, word_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > W_MAX) return W_MAX;
      if (s < W_MIN) return W_MIN;
      return s[63:0];
   endfunction

   function automatic word_type s_sub(word_type a, word_type b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > W_MAX) return W_MAX;
      if (s < W_MIN) return W_MIN;
      return s[63:0];
   endfunction

   function automatic word_type q_mul(word_type a, word_type b);
      logic neg;
      logic [63:0] ua, ub, r, lim;
      logic [127:0] prod;
      neg = a[63] ^ b[63];
      ua = a[63] ? 64'(-a) : a;
      ub = b[63] ? 64'(-b) : b;
      prod = {64'b0, ua} * {64'b0, ub};
      lim = neg ? 64'h8000000000000000 : 64'h7fffffffffffffff;
      if (prod[127:112] != 0) r = lim;
      else r = prod[111:48];
      if (r > lim) r = lim;
      return neg ? word_type'(-r) : word_type'(r);
   endfunction

   function automatic logic [63:0] log2_q24(logic [63:0] v, int fb);
      int msb;
      logic [63:0] mant, fr;
      if (v == 0) return 0;
      msb = 63;
      while (v[msb] == 1'b0) msb--;
      if (msb < fb) return 0;
      mant = (msb >= 30) ? (v >> (msb - 30)) : (v << (30 - msb));
      fr = 0;
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 30;
         fr = fr << 1;
         if (mant >= (64'd2 << 30)) begin
            fr[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (64'(msb - fb) << 24) | fr;
   endfunction

   function automatic word_type plane_coord(logic [63:0] pix, logic [63:0] size,
                                            logic [63:0] span, word_type ctr);
      logic [63:0] sz, frac;
      sz = (size == 0) ? 64'd1 : size;
      frac = (pix << FB) / sz;
      return s_add(q_mul(word_type'(span),
                         s_sub(word_type'(frac), word_type'(64'd1 << (FB - 1)))),
                   ctr);
   endfunction

   function automatic shade_type shade_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      word_type cx, cy, x, y, xx, yy, p;
      logic [63:0] hops, lz, ll, nu;
      shade_type s;
      cx = plane_coord(64'(px), view_w, view_sx, view_cx);
      cy = plane_coord(64'(py), view_h, view_sy, view_cy);
      x = 0; y = 0; xx = 0; yy = 0; hops = 0;
      while (s_add(xx, yy) <= (word_type'(4) <<< FB) && hops <= iter_limit) begin
         p = q_mul(x, y);
         y = s_add(s_add(p, p), cy);
         x = s_add(s_sub(xx, yy), cx);
         xx = q_mul(x, x);
         yy = q_mul(y, y);
         hops++;
      end
      if (hops < iter_limit) begin
         lz = log2_q24(64'(s_add(xx, yy)), FB);
         ll = log2_q24(lz, 24);
         nu = (ll >= (64'd1 << 24)) ? ll - (64'd1 << 24) : 64'd0;
         s.color = 8'(((nu * N_COLORS) >> 24) % N_COLORS);
         s.in_set = 1'b0;
      end else begin
         s.color = '0;
         s.in_set = 1'b1;
      end
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      logic nrv, ncv;
      step_type st;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         req_pixel_x <= '0;
         req_pixel_y <= '0;
         csr_index <= '0;
         csr_data <= '0;
         view_cx = 0; view_cy = 0;
         view_sx = 64'd1 << 50; view_sy = 64'd1 << 50;
         view_w = 640; view_h = 480; iter_limit = 256;
         drain_cnt = 0;
      end else begin
         nrv = req_valid;
         ncv = csr_valid;
         if (req_valid && req_ready) begin
            expected_shades.push_back(shade_pixel(req_pixel_x, req_pixel_y));
            nrv = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER_X: view_cx = {{11{csr_data[52]}}, csr_data};
               CSR_CENTER_Y: view_cy = {{11{csr_data[52]}}, csr_data};
               CSR_SPAN_X: view_sx = 64'(csr_data[50:0]);
               CSR_SPAN_Y: view_sy = 64'(csr_data[50:0]);
               CSR_IMAGE_WIDTH: view_w = 64'(csr_data[12:0]);
               CSR_IMAGE_HEIGHT: view_h = 64'(csr_data[12:0]);
               CSR_MAX_ITERATIONS: iter_limit = 64'(csr_data[15:0]);
               default: ;
            endcase
            ncv = 1'b0;
         end
         if (!nrv && !ncv && pending_steps.size() > 0) begin
            st = pending_steps[0];
            case (st.kind)
               STEP_PIXEL: if ($urandom_range(99) >= gap_pct) begin
                  req_pixel_x <= st.px;
                  req_pixel_y <= st.py;
                  nrv = 1'b1;
                  void'(pending_steps.pop_front());
               end
               STEP_CSR: begin
                  csr_index <= st.idx;
                  csr_data <= st.data;
                  ncv = 1'b1;
                  void'(pending_steps.pop_front());
               end
               STEP_DRAIN: if (expected_shades.size() == 0) begin
                  if (drain_cnt == 40) begin
                     drain_cnt = 0;
                     void'(pending_steps.pop_front());
                  end else begin
                     drain_cnt++;
                  end
               end
               STEP_MODE: begin
                  gap_pct = st.gap;
                  stall_pct = st.stall;
                  void'(pending_steps.pop_front());
               end
            endcase
         end
         req_valid <= nrv;
         csr_valid <= ncv;
      end
   end

   // monitor
   always @(posedge clock) begin
      shade_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_shades.size() == 0) begin
               report_mismatch("unexpected result", rsp_color_index, -1);
            end else begin
               want = expected_shades.pop_front();
               if (rsp_color_index !== want.color)
                  report_mismatch("color_index", rsp_color_index, want.color);
               if (rsp_inside_res !== want.in_set)
                  report_mismatch("inside_res", rsp_inside_res, want.in_set);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic add_step(step_kind_type k, csr_index_type idx, logic [CSR_DATA_W-1:0] d,
                           int px, int py);
      step_type st;
      st.kind = k; st.idx = idx; st.data = d;
      st.px = PIX_W'(px); st.py = PIX_W'(py);
      st.gap = gap_pct; st.stall = stall_pct;
      pending_steps.push_back(st);
   endtask

   task automatic add_mode(int gap, int stall);
      step_type st;
      st.kind = STEP_MODE; st.gap = gap; st.stall = stall;
      pending_steps.push_back(st);
   endtask

   task automatic add_view(logic [52:0] cx, logic [52:0] cy, logic [52:0] sx,
                           logic [52:0] sy, int w, int h, int it);
      add_step(STEP_DRAIN, CSR_CENTER_X, 0, 0, 0);
      add_step(STEP_CSR, CSR_CENTER_X, cx, 0, 0);
      add_step(STEP_CSR, CSR_CENTER_Y, cy, 0, 0);
      add_step(STEP_CSR, CSR_SPAN_X, sx, 0, 0);
      add_step(STEP_CSR, CSR_SPAN_Y, sy, 0, 0);
      add_step(STEP_CSR, CSR_IMAGE_WIDTH, 53'(w), 0, 0);
      add_step(STEP_CSR, CSR_IMAGE_HEIGHT, 53'(h), 0, 0);
      add_step(STEP_CSR, CSR_MAX_ITERATIONS, 53'(it), 0, 0);
   endtask

   function automatic logic [52:0] rand_center();
      logic [63:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(3) == 0) return 53'({{12{r[51]}}, r[51:0]});
      return 53'({{14{r[49]}}, r[49:0]});
   endfunction

   function automatic logic [52:0] rand_span();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return 53'(r[49:0]) + 1;
         1: return 53'(1) << 50;
         default: return (53'(r[47:0]) + 1) << $urandom_range(2);
      endcase
   endfunction

   task automatic add_random_phase(int gap, int stall, int n, int it_hi);
      int w, h;
      add_mode(gap, stall);
      for (int k = 0; k < n; k++) begin
         if (k % 50 == 0) begin
            w = ($urandom_range(9) == 0) ? 0 : $urandom_range(4096, 1);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(4096, 1);
            add_view(rand_center(), rand_center(), rand_span(), rand_span(), w, h,
                     ($urandom_range(19) == 0) ? 0 : $urandom_range(it_hi, 1));
         end
         if ($urandom_range(3) == 0)
            add_step(STEP_PIXEL, CSR_CENTER_X, 0, $urandom_range(4095), $urandom_range(4095));
         else
            add_step(STEP_PIXEL, CSR_CENTER_X, 0, $urandom_range(w), $urandom_range(h));
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      gap_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      // directed: reset view, corners, center and beyond-image pixels
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 0, 0);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 4095, 4095);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 639, 479);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 320, 240);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 0, 240);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 4095, 0);
      // zero iteration limit, zero image size
      add_view(0, 0, 53'd1 << 50, 53'd1 << 50, 0, 0, 0);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 0, 0);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 2048, 4095);
      // far centers with the largest limit escape fast
      add_view(53'd1 << 51, -(53'd1 << 51), 53'd1, 53'd1, 4096, 4096, 65535);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 0, 4095);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 4095, 0);
      add_view(-(53'd1 << 51), 53'd1 << 51, 53'd1 << 50, 53'd1 << 50, 1, 1, 65535);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 0, 0);
      add_step(STEP_PIXEL, CSR_CENTER_X, 0, 4095, 4095);
      // escape near the limit and shallow escapes around the edge
      add_view(0, 0, 53'd1 << 50, 53'd1 << 50, 4096, 4096, 3);
      for (int k = 0; k < 6; k++)
         add_step(STEP_PIXEL, CSR_CENTER_X, 0, 700 * k, 4095 - 700 * k);
      add_random_phase(0, 0, 300, 40);
      add_random_phase(52, 0, 300, 40);
      add_random_phase(0, 52, 300, 40);
      add_random_phase(38, 38, 300, 40);
      add_random_phase(0, 0, 30, 256);
      add_random_phase(38, 38, 170, 24);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_steps.size() > 0 || req_valid || csr_valid || expected_shades.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
`default_nettype wire
